FILE: design/tuple_dump_field_extractor_assert.svh
// assertion macros for the tuple dump field extractor
`ifndef TUPLE_DUMP_FIELD_EXTRACTOR_ASSERT_SVH
`define TUPLE_DUMP_FIELD_EXTRACTOR_ASSERT_SVH

`ifndef SYNTH
`define TDFE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tdfe assertion failed");
`define TDFE_ASSERT_RST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("tdfe reset assertion failed");
`else
`define TDFE_ASSERT(label, clk, rst, prop)
`define TDFE_ASSERT_RST(label, clk, prop)
`endif

`endif

FILE: design/tdfe_pkg.sv
// shared constants and types for the tuple dump field extractor
package tdfe_pkg;

   localparam int ByteWidth = 8;

   localparam logic [7:0] CH_OPEN    = 8'h28;
   localparam logic [7:0] CH_CLOSE   = 8'h29;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_QUOTE   = 8'h27;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_UNDER   = 8'h5F;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] DIGIT_BAD  = 8'hFF;

   localparam logic [2:0] PEND_NONE  = 3'd0;
   localparam logic [2:0] PEND_ESC   = 3'd1;
   localparam logic [2:0] PEND_HEX1  = 3'd2;
   localparam logic [2:0] PEND_HEX2  = 3'd3;
   localparam logic [2:0] PEND_SKIP1 = 3'd4;
   localparam logic [2:0] PEND_SKIP2 = 3'd5;

   localparam logic [2:0] PHASE_OPEN   = 3'd0;
   localparam logic [2:0] PHASE_FIRST  = 3'd1;
   localparam logic [2:0] PHASE_SECOND = 3'd2;
   localparam logic [2:0] PHASE_THIRD  = 3'd3;
   localparam logic [2:0] PHASE_FOURTH = 3'd4;
   localparam logic [2:0] PHASE_CLOSE  = 3'd5;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } tdfe_result_type;

   function automatic logic [7:0] digit_of(input logic [7:0] b);
      logic [7:0] d;
      d = DIGIT_BAD;
      if (b inside {[8'h30:8'h39]}) d = b - 8'h30;
      else if (b inside {[8'h41:8'h46]}) d = b - 8'h37;
      else if (b inside {[8'h61:8'h66]}) d = b - 8'h57;
      return d;
   endfunction

endpackage

FILE: design/tdfe_core.sv
// parser state registers and per-byte step logic
module tdfe_core
   import tdfe_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  logic [7:0]      in_byte,
   output tdfe_result_type result
);

`include "tuple_dump_field_extractor_assert.svh"

   logic [2:0] phase_ff, phase_in;
   logic [2:0] pend_ff, pend_in;
   logic [7:0] high_ff, high_in;
   logic [7:0] low_digit;
   logic [7:0] decoded;

   assign low_digit = digit_of(in_byte);
   assign decoded   = {high_ff[3:0], 4'b0000} + low_digit;

   always_comb begin
      phase_in     = phase_ff;
      pend_in      = PEND_NONE;
      high_in      = high_ff;
      result.valid = 1'b0;
      result.data  = in_byte;
      case (pend_ff)
         PEND_ESC: begin
            result.valid = 1'b1;
         end
         PEND_HEX1: begin
            high_in = low_digit;
            pend_in = PEND_HEX2;
         end
         PEND_HEX2: begin
            result.valid = 1'b1;
            result.data  = (decoded == CH_SPACE) ? CH_UNDER : decoded;
         end
         PEND_SKIP1: begin
            pend_in = PEND_NONE;
         end
         PEND_SKIP2: begin
            pend_in = PEND_SKIP1;
         end
         default: begin
            if (in_byte == CH_BSLASH) begin
               pend_in = PEND_ESC;
            end else if (in_byte == CH_PERCENT) begin
               pend_in = PEND_HEX1;
            end else begin
               case (phase_ff)
                  PHASE_OPEN: begin
                     if (in_byte == CH_OPEN) phase_in = PHASE_FIRST;
                  end
                  PHASE_FIRST: begin
                     if (in_byte == CH_COMMA) begin
                        phase_in = PHASE_SECOND;
                        pend_in  = PEND_SKIP1;
                     end
                  end
                  PHASE_SECOND: begin
                     result.valid = 1'b1;
                     if (in_byte == CH_QUOTE) begin
                        phase_in    = PHASE_THIRD;
                        pend_in     = PEND_SKIP2;
                        result.data = CH_SPACE;
                     end
                  end
                  PHASE_THIRD: begin
                     result.valid = 1'b1;
                     if (in_byte == CH_QUOTE) begin
                        phase_in    = PHASE_FOURTH;
                        pend_in     = PEND_SKIP1;
                        result.data = CH_SPACE;
                     end
                  end
                  PHASE_FOURTH: begin
                     result.valid = 1'b1;
                     if (in_byte == CH_COMMA) begin
                        phase_in    = PHASE_CLOSE;
                        result.data = CH_NEWLINE;
                     end
                  end
                  PHASE_CLOSE: begin
                     if (in_byte == CH_CLOSE) phase_in = PHASE_OPEN;
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_OPEN;
         pend_ff  <= PEND_NONE;
         high_ff  <= 8'h00;
      end else if (advance) begin
         phase_ff <= phase_in;
         pend_ff  <= pend_in;
         high_ff  <= high_in;
      end
   end

   // skipped bytes never produce output
   `TDFE_ASSERT(a_skip_silent, clock, reset, advance && (pend_ff == PEND_SKIP1 || pend_ff == PEND_SKIP2) |-> !result.valid)
   // a completed hex pair always produces a byte
   `TDFE_ASSERT(a_hex_emits, clock, reset, advance && pend_ff == PEND_HEX2 |-> result.valid)
   // phase holds while a byte is pending
   `TDFE_ASSERT(a_phase_hold, clock, reset, advance && pend_ff != PEND_NONE |=> $stable(phase_ff))

endmodule

FILE: design/tuple_dump_field_extractor.sv
// tuple dump field extractor top level: input register, step logic, output register
// path: a byte's result, if any, reaches rsp_ through the input and output registers
// throughput: one byte per cycle, limited only by rsp_stall through the output register
// reset: synchronous, clears the parser state and both pipeline valid flags
// the output register loads the core's combinational result when the core state advances
module tuple_dump_field_extractor
   import tdfe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte
);

`include "tuple_dump_field_extractor_assert.svh"

   logic                 in_vld_ff, in_vld_in;
   logic [ByteWidth-1:0] in_byte_ff;
   logic                 out_vld_ff, out_vld_in;
   logic [ByteWidth-1:0] out_byte_ff;
   logic                 advance;
   logic                 req_xfer;
   tdfe_result_type      result;

   assign advance   = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !advance;
   assign req_xfer  = req_valid && !req_stall;

   tdfe_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_byte (in_byte_ff),
      .result  (result)
   );

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_xfer) in_vld_in = 1'b1;
      else if (advance) in_vld_in = 1'b0;
      out_vld_in = out_vld_ff;
      if (advance) out_vld_in = result.valid;
      else if (!rsp_stall) out_vld_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) in_byte_ff <= req_in_byte;
      if (advance && result.valid) out_byte_ff <= result.data;
   end

   assign rsp_valid    = out_vld_ff;
   assign rsp_out_byte = out_byte_ff;

   // pipeline empty after reset
   `TDFE_ASSERT_RST(a_reset_empty, clock, reset |=> !rsp_valid && !in_vld_ff)
   // no stall toward the source without a byte held
   `TDFE_ASSERT(a_stall_held, clock, reset, req_stall |-> in_vld_ff)
   // a stalled output is never overwritten
   `TDFE_ASSERT(a_no_overwrite, clock, reset, rsp_valid && rsp_stall |-> !advance)

endmodule
